FILE: rtl/core/sha_pkg.sv
package sha_pkg;

	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       eom;
	} front_word_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	function automatic logic [31:0] ror(input logic [31:0] v, input int s);
		ror = (v >> s) | (v << (32 - s));
	endfunction

endpackage

FILE: rtl/core/sha_fifo.sv
module sha_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  sha_pkg::front_word_t wr_data,
	output logic                rd_valid,
	input  logic                rd_ready,
	output sha_pkg::front_word_t rd_data
);
	import sha_pkg::*;

	front_word_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_data  = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 2'd1;
			if (do_rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, do_wr} - {2'd0, do_rd};
		end
	end
endmodule

FILE: rtl/core/sha_core.sv
module sha_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha_pkg::front_word_t in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_digest,
	output logic [2:0]          out_index,
	output logic                out_last
);
	import sha_pkg::*;

	localparam logic [2:0] ST_FILL = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_PAD  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]  st_q;
	logic [31:0] blk_q [16];
	logic [5:0]  fill_q;
	logic [60:0] cnt_q;
	logic        pad_q;
	logic        len_q;
	logic        eom_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [6:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        ovld_q;

	logic [63:0] bits;
	logic [7:0]  pad_byte;
	logic [31:0] wt, s0, s1, ch, mj, t1, t2, x0, x1;
	logic        take, put_fill, put_pad;
	logic [7:0]  put_b;

	assign bits = {cnt_q, 3'b000};
	assign in_ready = (st_q == ST_FILL) && !eom_q;
	assign take = in_valid && in_ready;

	// len_q: the length field goes into the block being padded
	always_comb begin
		if (!pad_q) pad_byte = PAD_BYTE;
		else if (!len_q || fill_q < LEN_OFFSET) pad_byte = 8'h00;
		else pad_byte = bits[6'(63 - 8 * int'(fill_q[2:0])) -: 8];
	end

	assign put_fill = take && in_word.byte_valid;
	assign put_pad  = (st_q == ST_PAD);
	assign put_b    = put_pad ? pad_byte : in_word.data;

	always_comb begin
		x0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		x1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wt = (rnd_q < 7'd16) ? w_q[0] : (w_q[0] + x0 + w_q[9] + x1);
		s1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		s0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + s1 + ch + ROUND_K[rnd_q[5:0]] + wt;
		t2 = s0 + mj;
	end

	assign out_valid  = ovld_q;
	assign out_digest = h_q[oidx_q];
	assign out_index  = oidx_q;
	assign out_last   = (oidx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (put_fill || put_pad)
			blk_q[fill_q[5:2]][5'(31 - 8 * int'(fill_q[1:0])) -: 8] <= put_b;
		if (st_q == ST_LOAD) begin
			w_q <= blk_q;
			v_q <= h_q;
		end else if (st_q == ST_RND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wt;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_FILL;
			fill_q <= '0;
			cnt_q <= '0;
			pad_q <= 1'b0;
			len_q <= 1'b0;
			eom_q <= 1'b0;
			rnd_q <= '0;
			oidx_q <= '0;
			ovld_q <= 1'b0;
			h_q <= INIT_HASH;
		end else begin
			case (st_q)
				ST_FILL: begin
					if (eom_q) begin
						st_q <= ST_PAD;
						eom_q <= 1'b0;
					end else if (take) begin
						if (in_word.byte_valid) begin
							cnt_q <= cnt_q + 61'd1;
							fill_q <= fill_q + 6'd1;
						end
						eom_q <= in_word.eom;
						if (in_word.byte_valid && fill_q == 6'd63) st_q <= ST_LOAD;
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					pad_q <= 1'b1;
					if (!pad_q) len_q <= (fill_q < LEN_OFFSET);
					if (fill_q == 6'd63) st_q <= ST_LOAD;
				end
				ST_LOAD: begin
					rnd_q <= '0;
					st_q <= ST_RND;
				end
				ST_RND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd63) st_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (pad_q && len_q) begin
						st_q <= ST_OUT;
						ovld_q <= 1'b1;
						oidx_q <= '0;
					end else if (pad_q) begin
						len_q <= 1'b1;
						st_q <= ST_PAD;
					end else st_q <= ST_FILL;
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							ovld_q <= 1'b0;
							h_q <= INIT_HASH;
							cnt_q <= '0;
							pad_q <= 1'b0;
							len_q <= 1'b0;
							st_q <= ST_FILL;
						end
					end
				end
				default: st_q <= ST_FILL;
			endcase
		end
	end
endmodule

FILE: rtl/core/sha256_stream_hasher.sv
// channel | dir | tdata                       | tuser            | tlast
// s_axis  | in  | [7:0] data_byte             | [0] byte_valid   | end_of_message
// m_axis  | out | [31:0] digest_word          | [2:0] word_index | final_word
// Each full block is compressed at one round per cycle in a single shared round
// unit, during which input to the core stalls.
// End of message adds padding at one byte per cycle plus one or two compressions,
// then eight output words. A four-entry queue decouples input from the core.
// arst_n clears control state and the chain value.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] byte_valid
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,  // [2:0] word_index
	output logic        m_axis_tlast
);
	import sha_pkg::*;

	front_word_t in_w, q_w;
	logic q_valid, q_ready;

	assign in_w.data = s_axis_tdata;
	assign in_w.byte_valid = s_axis_tuser;
	assign in_w.eom = s_axis_tlast;

	sha_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(s_axis_tvalid), .wr_ready(s_axis_tready), .wr_data(in_w),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_w)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_word(q_w),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_digest(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast)
	);
endmodule

FILE: rtl/core/sha_checker.sv
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
		else $error("tlast mismatch");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
		else $error("word order");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tuser))
		else $error("index changed under stall");
endmodule

bind sha256_stream_hasher sha_checker u_chk (.*);

FILE: dv/sha256_stream_hasher_checker.sv
`timescale 1ns / 1ps

module sha256_stream_hasher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          errors,
	output int          pending
);
	import sha_pkg::*;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} digest_entry_t;

	logic [31:0] chain [8];
	logic [60:0] msg_len;
	logic [7:0]  blk [64];
	int          blk_fill;
	digest_entry_t digest_q [$];

	function automatic logic [31:0] rotr(logic [31:0] v, int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		{a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
			chain[4], chain[5], chain[6], chain[7]};
		for (int r = 0; r < 64; r++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[r] + w[r];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic absorb(logic [7:0] b);
		blk[blk_fill] = b;
		blk_fill++;
		if (blk_fill == 64) begin
			compress();
			blk_fill = 0;
		end
	endtask

	task automatic hash_word(logic [7:0] data, logic byte_valid, logic eom);
		logic [63:0] bits;
		digest_entry_t e;
		if (byte_valid) begin
			msg_len++;
			absorb(data);
		end
		if (eom) begin
			bits = {msg_len, 3'b000};
			absorb(PAD_BYTE);
			while (blk_fill != LEN_OFFSET)
				absorb(8'h00);
			for (int i = 0; i < 8; i++)
				absorb(bits[63-8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				e.digest_word = chain[i];
				e.word_index = i[2:0];
				e.final_word = (i == 7);
				digest_q.push_back(e);
			end
			chain = INIT_HASH;
			msg_len = '0;
			blk_fill = 0;
		end
	endtask

	assign pending = digest_q.size();

	always @(posedge clk or negedge arst_n) begin
		digest_entry_t e;
		if (!arst_n) begin
			chain = INIT_HASH;
			msg_len = '0;
			blk_fill = 0;
			errors = 0;
			digest_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected digest word %h idx %0d", m_axis_tdata, m_axis_tuser);
				end else begin
					e = digest_q.pop_front();
					if (e != {m_axis_tdata, m_axis_tuser, m_axis_tlast}) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
								e.digest_word, e.word_index, e.final_word,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				hash_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
		end
	end
endmodule

FILE: dv/sha256_stream_hasher_test.sv
`timescale 1ns / 1ps

module sha256_stream_hasher_test;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 0;
	logic        s_axis_tuser = 0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	int          errors;
	int          pending;
	bit          calm = 0;
	bit          hold_sink = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	sha256_stream_hasher dut (.*);

	sha256_stream_hasher_checker chk (.*);

	// receiver: random stalls, plus one long hold-off
	initial begin
		int n;
		bit held;
		held = 0;
		@(posedge clk);
		forever begin
			if (hold_sink && !held) begin
				held = 1;
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 11);
				m_axis_tready <= 0;
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				@(posedge clk);
			end
		end
	end

	task automatic send(logic [7:0] d, logic v, logic e);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		s_axis_tuser <= v;
		s_axis_tlast <= e;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_msg(int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send(8'($urandom), 1'b0, 1'b0);
			send(8'($urandom), 1'b1, (i == len - 1) && ($urandom_range(0, 1) == 1));
		end
		if (len == 0 || !s_axis_tlast)
			send(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int len;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty, extremes, idle words, block boundaries
		send(8'hff, 1'b0, 1'b1);
		send(8'h00, 1'b1, 1'b1);
		send(8'hff, 1'b1, 1'b1);
		send(8'h55, 1'b0, 1'b0);
		send(8'haa, 1'b1, 1'b0);
		send(8'h3c, 1'b0, 1'b1);
		for (int i = 0; i < 55; i++)
			send(i[7:0], 1'b1, i == 54);
		send_msg(56);
		send_msg(64);
		// pause until everything drained
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		hold_sink = 1;
		send_msg(3);
		send_msg(1);
		for (int k = 0; k < 5; k++) begin
			if (k == 3)
				calm = 1;
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 5);
			send_msg(len);
		end
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("** sha256_stream_hasher: PASSED **");
		else
			$display("** sha256_stream_hasher: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** sha256_stream_hasher: FAILED **");
		$finish;
	end
endmodule
